### sv/fhp_pkg.sv
`default_nettype none

package fhp_pkg;

  localparam int unsigned POS_W = 16;

  localparam logic [POS_W-1:0] ETH_HDR = 16'd14;
  localparam logic [POS_W-1:0] IP4_MIN = 16'd20;
  localparam logic [POS_W-1:0] IP6_HDR = 16'd40;
  localparam logic [POS_W-1:0] TCP_MIN = 16'd20;
  localparam logic [POS_W-1:0] UDP_HDR = 16'd8;

  localparam logic [3:0] VER_IPV4 = 4'd4;
  localparam logic [3:0] VER_IPV6 = 4'd6;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] ST_IPV4_OK  = 3'd0;
  localparam logic [2:0] ST_IPV6_OK  = 3'd1;
  localparam logic [2:0] ST_SHORT    = 3'd2;
  localparam logic [2:0] ST_BAD_VER  = 3'd3;
  localparam logic [2:0] ST_TRUNC_IP = 3'd4;
  localparam logic [2:0] ST_TRUNC_TP = 3'd5;

  localparam int unsigned IOT_N = 44;

  localparam logic [23:0] IOT_OUI [IOT_N] = '{
    24'hb827eb, 24'hdca632, 24'he45f01, 24'h001788, 24'h18b430, 24'h641666,
    24'hd8334f, 24'h54607e, 24'h4465d0, 24'hfc65de, 24'h44650d, 24'h74c246,
    24'hf0272d, 24'ha002dc, 24'hcc9e00, 24'hb0b982, 24'hb4750e, 24'h6c4008,
    24'h0021d1, 24'h000d6f, 24'h286c07, 24'h606bff, 24'hec1a59, 24'hd83add,
    24'h5ccf7f, 24'ha020a6, 24'h30aea4, 24'h240ac4, 24'h3c71bf, 24'h24b2de,
    24'hac233f, 24'h98076b, 24'hb0be76, 24'h50c7bf, 24'h10feed, 24'h7cf666,
    24'hd073d5, 24'h48a6b8, 24'h54a5ef, 24'hb8e937, 24'hc05627, 24'h8ca9ff,
    24'h703a51, 24'he8db84
  };

  // Everything the capture side collected for one frame.
  typedef struct packed {
    logic [POS_W-1:0] cap;
    logic [3:0]       ver;
    logic [3:0]       ihl;
    logic [3:0]       tcp_words;
    logic [63:0]      src_hi;
    logic [63:0]      src_lo;
    logic [63:0]      dst_hi;
    logic [63:0]      dst_lo;
    logic [7:0]       proto;
    logic [31:0]      ports;
    logic [7:0]       flags;
    logic [23:0]      oui;
  } frame_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [63:0]      src_addr_hi;
    logic [63:0]      src_addr_lo;
    logic [63:0]      dst_addr_hi;
    logic [63:0]      dst_addr_lo;
    logic [7:0]       protocol;
    logic [15:0]      l4_src;
    logic [15:0]      l4_dst;
    logic [7:0]       l4_flags;
    logic [15:0]      l4_data_len;
    logic [23:0]      src_oui;
    logic             vendor_hit;
  } result_t;

  // Queue handshake between capture side and finish side.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic oui_match(input logic [23:0] oui);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < IOT_N; i++) begin
      if (IOT_OUI[i] == oui) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

`default_nettype wire

### sv/fhp_capture.sv
`default_nettype none

module fhp_capture #(
  parameter int unsigned MAX_CAPTURE = 65535
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            beat_i,
  input  wire logic [7:0]      data_i,
  input  wire logic            last_i,
  output logic                 push_o,
  output fhp_pkg::frame_t      frame_o
);

  fhp_pkg::frame_t st_q, st_d;

  logic                     take;
  logic                     in_ip;
  logic                     in_tp;
  logic [fhp_pkg::POS_W-1:0] q;
  logic [fhp_pkg::POS_W-1:0] hdr;
  logic [fhp_pkg::POS_W-1:0] t;
  logic [3:0]               ver_n;
  logic [3:0]               ihl_n;

  always_comb begin
    st_d  = st_q;
    take  = st_q.cap < fhp_pkg::POS_W'(MAX_CAPTURE);
    in_ip = st_q.cap >= fhp_pkg::ETH_HDR;
    q     = st_q.cap - fhp_pkg::ETH_HDR;
    ver_n = (in_ip && q == '0) ? data_i[7:4] : st_q.ver;
    ihl_n = (in_ip && q == '0) ? data_i[3:0] : st_q.ihl;
    hdr   = (ver_n == fhp_pkg::VER_IPV4) ? {10'd0, ihl_n, 2'b00} : fhp_pkg::IP6_HDR;
    t     = q - hdr;
    in_tp = q >= hdr;

    if (take) begin
      st_d.cap = st_q.cap + 1'b1;
      if (st_q.cap >= 16'd6 && st_q.cap <= 16'd8) st_d.oui = {st_q.oui[15:0], data_i};
      if (in_ip) begin
        st_d.ver = ver_n;
        st_d.ihl = ihl_n;
        if (ver_n == fhp_pkg::VER_IPV4) begin
          if (q == 16'd9) st_d.proto = data_i;
          if (q >= 16'd12 && q <= 16'd15) st_d.src_lo = {32'd0, st_q.src_lo[23:0], data_i};
          if (q >= 16'd16 && q <= 16'd19) st_d.dst_lo = {32'd0, st_q.dst_lo[23:0], data_i};
        end else if (ver_n == fhp_pkg::VER_IPV6) begin
          if (q == 16'd6) st_d.proto = data_i;
          if (q >= 16'd8 && q <= 16'd15)  st_d.src_hi = {st_q.src_hi[55:0], data_i};
          if (q >= 16'd16 && q <= 16'd23) st_d.src_lo = {st_q.src_lo[55:0], data_i};
          if (q >= 16'd24 && q <= 16'd31) st_d.dst_hi = {st_q.dst_hi[55:0], data_i};
          if (q >= 16'd32 && q <= 16'd39) st_d.dst_lo = {st_q.dst_lo[55:0], data_i};
        end
        // Transport bytes are picked by position, even inside a short IPv4 header.
        if ((ver_n == fhp_pkg::VER_IPV4 || ver_n == fhp_pkg::VER_IPV6) && in_tp) begin
          if (t <= 16'd3)  st_d.ports     = {st_q.ports[23:0], data_i};
          if (t == 16'd12) st_d.tcp_words = data_i[7:4];
          if (t == 16'd13) st_d.flags     = data_i;
        end
      end
    end
  end

  assign push_o  = beat_i && last_i;
  assign frame_o = st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (beat_i) begin
      if (last_i) begin
        st_q <= '0;
      end else begin
        st_q <= st_d;
      end
    end
  end

endmodule

`default_nettype wire

### sv/fhp_queue.sv
`default_nettype none

module fhp_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire fhp_pkg::frame_t  data_i,
  input  wire logic             pop_i,
  output fhp_pkg::frame_t       data_o,
  output fhp_pkg::q_stat_t      stat_o
);

  fhp_pkg::frame_t mem_q [2];
  logic            wr_ptr_q;
  logic            rd_ptr_q;
  logic [1:0]      count_q;

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = count_q == 2'd2;
  assign stat_o.empty = count_q == 2'd0;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/fhp_finish.sv
`default_nettype none

module fhp_finish (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire fhp_pkg::frame_t  frame_i,
  input  wire logic             valid_i,
  output logic                  pop_o,
  input  wire logic             ready_i,
  output logic                  valid_o,
  output fhp_pkg::result_t      result_o
);

  // Stage A: length checks and table lookup.
  logic                      a_valid_q;
  fhp_pkg::frame_t           a_fr_q;
  logic                      a_short_q, a_badver_q, a_truncip_q, a_iot_q;
  logic [fhp_pkg::POS_W-1:0] a_tp_q;

  logic                      a_ready, b_ready;
  logic                      is_v4, is_v6;
  logic [fhp_pkg::POS_W-1:0] hdr_tot;
  logic                      trunc_ip;

  // Stage B: the result register.
  logic                      out_valid_q;
  fhp_pkg::result_t          res_q, res_d;
  logic [fhp_pkg::POS_W-1:0] th;

  assign b_ready = !out_valid_q || ready_i;
  assign a_ready = !a_valid_q || b_ready;
  assign pop_o   = valid_i && a_ready;

  always_comb begin
    is_v4    = frame_i.ver == fhp_pkg::VER_IPV4;
    is_v6    = frame_i.ver == fhp_pkg::VER_IPV6;
    hdr_tot  = is_v4 ? fhp_pkg::ETH_HDR + {10'd0, frame_i.ihl, 2'b00}
                     : fhp_pkg::ETH_HDR + fhp_pkg::IP6_HDR;
    trunc_ip = frame_i.cap < hdr_tot ||
               (is_v4 && frame_i.cap < fhp_pkg::ETH_HDR + fhp_pkg::IP4_MIN);
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      a_fr_q      <= frame_i;
      a_short_q   <= frame_i.cap < fhp_pkg::ETH_HDR;
      a_badver_q  <= !(is_v4 || is_v6);
      a_truncip_q <= trunc_ip;
      a_iot_q     <= fhp_pkg::oui_match(frame_i.oui);
      a_tp_q      <= frame_i.cap - hdr_tot;
    end
  end

  always_comb begin
    res_d = '0;
    th    = {10'd0, a_fr_q.tcp_words, 2'b00};
    if (a_short_q) begin
      res_d.status = fhp_pkg::ST_SHORT;
    end else begin
      res_d.src_oui    = a_fr_q.oui;
      res_d.vendor_hit = a_iot_q;
      if (a_badver_q) begin
        res_d.status = fhp_pkg::ST_BAD_VER;
      end else if (a_truncip_q) begin
        res_d.status = fhp_pkg::ST_TRUNC_IP;
      end else begin
        res_d.src_addr_hi = a_fr_q.src_hi;
        res_d.src_addr_lo = a_fr_q.src_lo;
        res_d.dst_addr_hi = a_fr_q.dst_hi;
        res_d.dst_addr_lo = a_fr_q.dst_lo;
        res_d.protocol    = a_fr_q.proto;
        res_d.status      = (a_fr_q.ver == fhp_pkg::VER_IPV4) ? fhp_pkg::ST_IPV4_OK
                                                              : fhp_pkg::ST_IPV6_OK;
        if (a_fr_q.proto == fhp_pkg::PROTO_TCP) begin
          if (a_tp_q < fhp_pkg::TCP_MIN) begin
            res_d.status = fhp_pkg::ST_TRUNC_TP;
          end else begin
            res_d.l4_src      = a_fr_q.ports[31:16];
            res_d.l4_dst      = a_fr_q.ports[15:0];
            res_d.l4_flags    = a_fr_q.flags;
            res_d.l4_data_len = (a_tp_q > th) ? a_tp_q - th : '0;
          end
        end else if (a_fr_q.proto == fhp_pkg::PROTO_UDP) begin
          if (a_tp_q < fhp_pkg::UDP_HDR) begin
            res_d.status = fhp_pkg::ST_TRUNC_TP;
          end else begin
            res_d.l4_src      = a_fr_q.ports[31:16];
            res_d.l4_dst      = a_fr_q.ports[15:0];
            res_d.l4_data_len = a_tp_q - fhp_pkg::UDP_HDR;
          end
        end else begin
          res_d.l4_data_len = a_tp_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_valid_q && b_ready) res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_ready) a_valid_q   <= valid_i;
      if (b_ready) out_valid_q <= a_valid_q;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

### sv/frame_header_parser.sv
// Frame header parser: feed a captured Ethernet frame one byte per beat on
// s_axis, starting at the destination MAC, with tlast on the final byte.
// For each frame one result beat leaves on m_axis: status on tuser, and on
// tdata the IPv4/IPv6 addresses, protocol, TCP/UDP ports, TCP flags,
// payload length after the transport header, source OUI and an IoT vendor
// flag. Bytes past MAX_CAPTURE are dropped and the length saturates there.
// Rate: one byte per clock while s_axis_tready is high, back to back, frames
// of any length including one byte. The capture side takes every accepted
// byte; on the last byte it pushes a frame record into a two-entry queue, and
// a two-stage finish pipeline (length checks and table lookup, then result
// register) turns one record per clock into a result while m_axis is not stalled.
// s_axis_tready drops only when the queue is full, which needs four frames
// outstanding behind a stalled m_axis: one in the result register, one in the
// first finish stage and two in the queue.
`default_nettype none

module frame_header_parser #(
  parameter int unsigned MAX_CAPTURE = 65535
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // data_byte [7:0]
  input  wire logic         s_axis_tlast,   // last_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // src_addr_hi [63:0], src_addr_lo [127:64], dst_addr_hi [191:128],
  // dst_addr_lo [255:192], protocol [263:256], l4_src [279:264],
  // l4_dst [295:280], l4_flags [303:296], l4_data_len [319:304],
  // src_oui [343:320], vendor_hit [344], zero fill [351:345]
  output logic [351:0]      m_axis_tdata,
  output logic [2:0]        m_axis_tuser    // status [2:0]
);

  logic              beat;
  logic              push;
  logic              pop;
  fhp_pkg::frame_t   frame_in;
  fhp_pkg::frame_t   frame_out;
  fhp_pkg::q_stat_t  q_stat;
  fhp_pkg::result_t  res;

  // Accept a byte whenever the queue can take a finished frame.
  assign s_axis_tready = !q_stat.full;
  assign beat          = s_axis_tvalid && s_axis_tready;

  // Front: walk the header byte by byte, hand over a record on tlast.
  fhp_capture #(
    .MAX_CAPTURE (MAX_CAPTURE)
  ) u_capture (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .beat_i  (beat),
    .data_i  (s_axis_tdata),
    .last_i  (s_axis_tlast),
    .push_o  (push),
    .frame_o (frame_in)
  );

  // Decouple capture from result delivery.
  fhp_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (frame_in),
    .pop_i  (pop),
    .data_o (frame_out),
    .stat_o (q_stat)
  );

  // Back: classify the record and build the result beat.
  fhp_finish u_finish (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .frame_i  (frame_out),
    .valid_i  (!q_stat.empty),
    .pop_o    (pop),
    .ready_i  (m_axis_tready),
    .valid_o  (m_axis_tvalid),
    .result_o (res)
  );

  assign m_axis_tuser = res.status;
  assign m_axis_tdata = {7'd0, res.vendor_hit, res.src_oui, res.l4_data_len,
                         res.l4_flags, res.l4_dst, res.l4_src, res.protocol,
                         res.dst_addr_lo, res.dst_addr_hi, res.src_addr_lo,
                         res.src_addr_hi};

`ifndef SYNTHESIS
  // Never pop a record from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // A full queue must hold off the capture side.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.full |-> !push)
    else $error("frame record pushed into full queue");

  // Short frames carry nothing but their status.
  a_short_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == fhp_pkg::ST_SHORT) |-> m_axis_tdata == '0)
    else $error("short frame result carries data");

  // Only defined status codes leave the block.
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tuser <= fhp_pkg::ST_TRUNC_TP)
    else $error("undefined status code");
`endif

endmodule

`default_nettype wire
